/* design/ise_pkg.sv */
// ise_pkg: shared types and constants for the interpolation search engine
// item structs, function codes, controller/datapath command and status structs
// no dependencies
`default_nettype none
package ise_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int VAL_W     = 32;
  localparam int IDX_W     = 5;
  localparam int POS_W     = 5;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  // store read address select
  localparam logic [1:0] RD_LEFT  = 2'd0;
  localparam logic [1:0] RD_RIGHT = 2'd1;
  localparam logic [1:0] RD_MID   = 2'd2;

  // where a result takes its position from
  localparam logic [1:0] HIT_NONE = 2'd0;
  localparam logic [1:0] HIT_MID  = 2'd1;
  localparam logic [1:0] HIT_LEFT = 2'd2;

  typedef struct packed {
    logic                    func;
    logic [IDX_W-1:0]        entry_index;
    logic signed [VAL_W-1:0] entry_value;
    logic signed [VAL_W-1:0] search_key;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } out_item_t;

  typedef struct packed {
    logic       write;
    logic       load_search;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       cap_lv;
    logic       load_div;
    logic       clear_q;
    logic       div_step;
    logic       cap_mid;
    logic       go_left;
    logic       go_right;
    logic       emit;
    logic [1:0] hit_src;
  } cmd_t;

  typedef struct packed {
    logic loop_ok;
    logic in_range;
    logic ends_eq;
    logic div_done;
    logic mid_lt;
    logic mid_gt;
    logic left_ok;
    logic fin_eq;
  } sts_t;

endpackage
`default_nettype wire

/* design/ise_ctrl.sv */
// ise_ctrl: sequencer for write and search items
// drives ise_dpath through ise_pkg::cmd_t, reads ise_pkg::sts_t
`default_nettype none
module ise_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          func,
  input  wire ise_pkg::sts_t sts,
  output ise_pkg::cmd_t      cmd,
  output logic               busy,
  output logic               out_valid
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CHECK   = 4'd1;
  localparam logic [3:0] S_RD_L    = 4'd2;
  localparam logic [3:0] S_RD_R    = 4'd3;
  localparam logic [3:0] S_DIV     = 4'd4;
  localparam logic [3:0] S_MID_RD  = 4'd5;
  localparam logic [3:0] S_MID_CMP = 4'd6;
  localparam logic [3:0] S_FIN_RD  = 4'd7;
  localparam logic [3:0] S_FIN_CMP = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (func == ise_pkg::FUNC_WRITE) begin
            cmd.write = 1'b1;
          end else begin
            cmd.load_search = 1'b1;
            state_nxt       = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (sts.loop_ok) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ise_pkg::RD_LEFT;
          state_nxt  = S_RD_L;
        end else begin
          state_nxt = S_FIN_RD;
        end
      end
      S_RD_L: begin
        cmd.cap_lv = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ise_pkg::RD_RIGHT;
        state_nxt  = S_RD_R;
      end
      S_RD_R: begin
        priority if (!sts.in_range) begin
          state_nxt = S_FIN_RD;
        end else if (sts.ends_eq) begin
          // flat span: probe at left
          cmd.clear_q = 1'b1;
          state_nxt   = S_MID_RD;
        end else begin
          cmd.load_div = 1'b1;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = S_MID_RD;
        end
      end
      S_MID_RD: begin
        cmd.cap_mid = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = ise_pkg::RD_MID;
        state_nxt   = S_MID_CMP;
      end
      S_MID_CMP: begin
        priority if (sts.mid_lt) begin
          cmd.go_left = 1'b1;
          state_nxt   = S_CHECK;
        end else if (sts.mid_gt) begin
          cmd.go_right = 1'b1;
          state_nxt    = S_CHECK;
        end else begin
          cmd.emit    = 1'b1;
          cmd.hit_src = ise_pkg::HIT_MID;
          state_nxt   = S_IDLE;
        end
      end
      S_FIN_RD: begin
        if (sts.left_ok) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ise_pkg::RD_LEFT;
          state_nxt  = S_FIN_CMP;
        end else begin
          cmd.emit    = 1'b1;
          cmd.hit_src = ise_pkg::HIT_NONE;
          state_nxt   = S_IDLE;
        end
      end
      S_FIN_CMP: begin
        cmd.emit    = 1'b1;
        cmd.hit_src = sts.fin_eq ? ise_pkg::HIT_LEFT : ise_pkg::HIT_NONE;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.emit;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

/* design/ise_dpath.sv */
// ise_dpath: value store, search bounds, probe multiplier and restoring divider
// uses ise_pkg types; commanded by ise_ctrl
`default_nettype none
module ise_dpath #(
  parameter int DEPTH = ise_pkg::DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire ise_pkg::in_item_t in_data,
  input  wire ise_pkg::cmd_t     cmd,
  output ise_pkg::sts_t          sts,
  output ise_pkg::out_item_t     out_data
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // store address
  localparam int LW = $clog2(DEPTH + 1);                // bound, holds DEPTH
  localparam int XW = ((IW > ise_pkg::IDX_W) ? IW : ise_pkg::IDX_W) + 1;
  localparam int PW = ise_pkg::VAL_W + IW;              // product / remainder
  localparam int CW = $clog2(IW + 1);
  localparam int VW = ise_pkg::VAL_W;

  logic [VW-1:0]        mem [DEPTH];
  logic [VW-1:0]        rdata_r;
  logic signed [VW-1:0] key_r;
  logic signed [VW-1:0] lv_r;
  logic [LW-1:0]        left_r, left_nxt;
  logic [LW-1:0]        rp1_r, rp1_nxt;   // right + 1
  logic [IW-1:0]        q_r, q_nxt;
  logic [PW-1:0]        rem_r, rem_nxt;
  logic [PW-1:0]        dsh_r, dsh_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [IW-1:0]        mid_r;
  ise_pkg::out_item_t   out_r;

  logic [XW-1:0] widx;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] left_a, right_a, mid_a, span;
  logic [VW-1:0] diff_kl, den;
  logic [PW-1:0] prod;
  logic          ge;
  logic [IW-1:0] pos_sel;

  assign widx    = XW'(in_data.entry_index);
  assign left_a  = left_r[IW-1:0];
  assign right_a = IW'(rp1_r - LW'(1));
  assign mid_a   = left_a + q_r;
  assign span    = right_a - left_a;
  // key >= A[left] and A[right] > A[left] here, so both fit unsigned
  assign diff_kl = VW'(key_r - lv_r);
  assign den     = rdata_r - VW'(lv_r);
  assign prod    = PW'(diff_kl) * PW'(span);
  assign ge      = (rem_r >= dsh_r);

  always_comb begin
    unique case (cmd.rd_sel)
      ise_pkg::RD_LEFT:  rd_addr = left_a;
      ise_pkg::RD_RIGHT: rd_addr = right_a;
      ise_pkg::RD_MID:   rd_addr = mid_a;
      default:           rd_addr = left_a;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.write && (widx < XW'(DEPTH))) begin
      mem[widx[IW-1:0]] <= in_data.entry_value;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_comb begin
    left_nxt = left_r;
    rp1_nxt  = rp1_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    cnt_nxt  = cnt_r;
    if (cmd.load_search) begin
      left_nxt = '0;
      rp1_nxt  = LW'(DEPTH);
    end
    if (cmd.go_left) begin
      left_nxt = LW'(mid_r) + LW'(1);
    end
    if (cmd.go_right) begin
      rp1_nxt = LW'(mid_r);
    end
    if (cmd.clear_q) begin
      q_nxt = '0;
    end
    if (cmd.load_div) begin
      rem_nxt = prod;
      dsh_nxt = PW'(den) << (IW - 1);
      cnt_nxt = CW'(IW - 1);
      q_nxt   = '0;
    end
    if (cmd.div_step) begin
      // one quotient bit per cycle, msb first
      if (ge) begin
        rem_nxt = rem_r - dsh_r;
      end
      q_nxt   = IW'({q_r, ge});
      dsh_nxt = dsh_r >> 1;
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_comb begin
    unique case (cmd.hit_src)
      ise_pkg::HIT_MID:  pos_sel = mid_r;
      ise_pkg::HIT_LEFT: pos_sel = left_a;
      default:           pos_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    left_r <= left_nxt;
    rp1_r  <= rp1_nxt;
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    cnt_r  <= cnt_nxt;
    if (cmd.load_search) begin
      key_r <= in_data.search_key;
    end
    if (cmd.cap_lv) begin
      lv_r <= $signed(rdata_r);
    end
    if (cmd.cap_mid) begin
      mid_r <= mid_a;
    end
    if (cmd.emit) begin
      out_r.found    <= (cmd.hit_src != ise_pkg::HIT_NONE);
      out_r.position <= ise_pkg::POS_W'(pos_sel);
    end
  end

  always_comb begin
    sts.loop_ok  = (left_r < rp1_r);
    sts.in_range = (lv_r <= key_r) && ($signed(rdata_r) >= key_r);
    sts.ends_eq  = (rdata_r == VW'(lv_r));
    sts.div_done = (cnt_r == '0);
    sts.mid_lt   = ($signed(rdata_r) < key_r);
    sts.mid_gt   = ($signed(rdata_r) > key_r);
    sts.left_ok  = (left_r < LW'(DEPTH));
    sts.fin_eq   = ($signed(rdata_r) == key_r);
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

/* design/interpolation_search_engine_core.sv */
// channel   ports                   handshake
// input     start, busy, in_data    taken when start && !busy
// result    out_valid, out_data     one-cycle strobe, no back-pressure
//
// a write item leaves busy low and gives no result; busy holds off new items during a search
// a search probe steps through check, two end reads, the divider (one quotient bit at a time),
// probe read and compare, with no divider steps on a flat span; one probe on evenly spread
// data, up to DEPTH at worst, then on a miss the loop is left and the entry at left is checked
// the result strobe comes in the same cycle that busy drops; the receiver cannot stall it
// the store has one read port; reset clears only the sequencer, not the store
`default_nettype none
module interpolation_search_engine_core #(
  parameter int DEPTH = ise_pkg::DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire ise_pkg::in_item_t in_data,
  output logic                   out_valid,
  output ise_pkg::out_item_t     out_data
);

  ise_pkg::cmd_t cmd;
  ise_pkg::sts_t sts;

  ise_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .func      (in_data.func),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  ise_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

`ifndef NO_ASSERTIONS
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.func == ise_pkg::FUNC_WRITE) |=> !out_valid)
    else $error("write item produced a result");

  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.func == ise_pkg::FUNC_SEARCH) |=> busy)
    else $error("search item did not start");

  a_miss_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.found) |-> (out_data.position == '0))
    else $error("miss with nonzero position");
`endif

endmodule
`default_nettype wire

/* tb/tb.sv */
// tb: self-checking testbench for interpolation_search_engine_core
// fills the store, runs searches and compares each result against a local search model
// depends on ise_pkg and interpolation_search_engine_core
`timescale 1ns / 1ps
module tb;

  localparam int STORE_DEPTH = ise_pkg::DEPTH_DEF;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int TAIL_CYCLES = 40;
  localparam logic signed [ise_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [ise_pkg::VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam int RANDOM_ITEMS = 1800;

  typedef enum int {
    FILL_SPREAD, FILL_SORTED, FILL_CLUSTER, FILL_FLAT, FILL_SKEW, FILL_UNSORTED
  } fill_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  ise_pkg::in_item_t in_data = '0;
  logic busy;
  logic out_valid;
  ise_pkg::out_item_t out_data;

  logic signed [ise_pkg::VAL_W-1:0] shadow_store [STORE_DEPTH];
  logic signed [ise_pkg::VAL_W-1:0] fill_vals [STORE_DEPTH];
  ise_pkg::out_item_t expected_lookups [$];
  int mismatch_count = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  int burst_left = 0;

  interpolation_search_engine_core #(.DEPTH(STORE_DEPTH)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  function automatic longint stored_at(longint i);
    return longint'(shadow_store[int'(i % STORE_DEPTH)]);
  endfunction

  // interpolation search over the shadow store, with wide exact arithmetic
  function automatic ise_pkg::out_item_t lookup_result(logic signed [ise_pkg::VAL_W-1:0] key);
    longint k, lo, hi, lv, rv, mv, mid, num, den;
    bit hit, searching;
    longint pos;
    ise_pkg::out_item_t r;
    k = longint'(key);
    lo = 0;
    hi = STORE_DEPTH - 1;
    hit = 1'b0;
    pos = 0;
    searching = 1'b1;
    while (searching && lo <= hi) begin
      lv = stored_at(lo);
      rv = stored_at(hi);
      if (!(lv <= k && rv >= k)) begin
        searching = 1'b0;
      end else begin
        if (rv == lv) begin
          mid = lo;
        end else begin
          num = (k - lv) * (hi - lo);
          den = rv - lv;
          mid = lo + num / den;
        end
        mv = stored_at(mid);
        if (mv < k) begin
          lo = mid + 1;
        end else if (mv > k) begin
          hi = mid - 1;
        end else begin
          hit = 1'b1;
          pos = mid;
          searching = 1'b0;
        end
      end
    end
    if (!hit && lo >= 0 && lo < STORE_DEPTH && stored_at(lo) == k) begin
      hit = 1'b1;
      pos = lo;
    end
    r.found = hit;
    r.position = hit ? pos[ise_pkg::POS_W-1:0] : '0;
    return r;
  endfunction

  // sender bursts: random length, random gap after each burst
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(4, 20) : $urandom_range(1, 3))
        @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  task automatic send_item(input ise_pkg::in_item_t item);
    start <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (item.func == ise_pkg::FUNC_WRITE) shadow_store[item.entry_index] = item.entry_value;
    else expected_lookups.push_back(lookup_result(item.search_key));
    pace();
  endtask

  task automatic write_entry(input int idx, input logic signed [ise_pkg::VAL_W-1:0] val);
    ise_pkg::in_item_t it;
    it.func = ise_pkg::FUNC_WRITE;
    it.entry_index = idx[ise_pkg::IDX_W-1:0];
    it.entry_value = val;
    it.search_key = $urandom;
    send_item(it);
  endtask

  task automatic search_key(input logic signed [ise_pkg::VAL_W-1:0] key);
    ise_pkg::in_item_t it;
    it.func = ise_pkg::FUNC_SEARCH;
    it.entry_index = $urandom;
    it.entry_value = $urandom;
    it.search_key = key;
    send_item(it);
  endtask

  task automatic sort_fill();
    logic signed [ise_pkg::VAL_W-1:0] v;
    int j;
    for (int i = 1; i < STORE_DEPTH; i++) begin
      v = fill_vals[i];
      j = i - 1;
      while (j >= 0 && fill_vals[j] > v) begin
        fill_vals[j + 1] = fill_vals[j];
        j--;
      end
      fill_vals[j + 1] = v;
    end
  endtask

  function automatic logic signed [ise_pkg::VAL_W-1:0] clamp_val(longint v);
    if (v > longint'(VAL_MAX)) return VAL_MAX;
    if (v < longint'(VAL_MIN)) return VAL_MIN;
    return v[ise_pkg::VAL_W-1:0];
  endfunction

  task automatic load_store(input fill_mode_t mode);
    longint base, step;
    logic signed [ise_pkg::VAL_W-1:0] flat;
    base = longint'($signed($urandom));
    step = $urandom_range(1, 1 << 24);
    flat = $urandom;
    case ($urandom_range(0, 3))
      0: flat = VAL_MIN;
      1: flat = VAL_MAX;
      default: ;
    endcase
    for (int i = 0; i < STORE_DEPTH; i++) begin
      case (mode)
        FILL_SPREAD:  fill_vals[i] = clamp_val(base + i * step);
        FILL_CLUSTER: fill_vals[i] = clamp_val(base + $urandom_range(0, 40));
        FILL_FLAT:    fill_vals[i] = flat;
        // exponential growth forces many probes
        FILL_SKEW:    fill_vals[i] = clamp_val(longint'(VAL_MIN) + (longint'(1) << i) - 1
                                               + (step << 6));
        default:      fill_vals[i] = $urandom;
      endcase
    end
    if (mode == FILL_SORTED || mode == FILL_CLUSTER) begin
      sort_fill();
      if ($urandom_range(0, 3) == 0) fill_vals[0] = VAL_MIN;
      if ($urandom_range(0, 3) == 0) fill_vals[STORE_DEPTH-1] = VAL_MAX;
    end
    if ($urandom_range(0, 1) == 0) begin
      for (int i = 0; i < STORE_DEPTH; i++) write_entry(i, fill_vals[i]);
    end else begin
      for (int i = STORE_DEPTH - 1; i >= 0; i--) write_entry(i, fill_vals[i]);
    end
  endtask

  // sorted store with a run of duplicates, ends first away from the value extremes, then at them
  task automatic test_store_extremes();
    for (int i = 0; i < STORE_DEPTH; i++) begin
      if (i >= 10 && i <= 12) write_entry(i, -6000);
      else write_entry(i, (i - 16) * 1000);
    end
    search_key(-16000);
    search_key(15000);
    search_key(-6000);
    search_key(2500);
    search_key(0);
    // keys outside the store range stop the loop at once
    search_key(VAL_MIN);
    search_key(VAL_MAX);
    search_key(-16001);
    write_entry(0, VAL_MIN);
    write_entry(STORE_DEPTH - 1, VAL_MAX);
    search_key(VAL_MIN);
    search_key(VAL_MAX);
    search_key(VAL_MAX - 1);
  endtask

  task automatic test_unsorted_store();
    write_entry(16, VAL_MAX - 5);
    search_key(VAL_MAX - 5);
    search_key(1000);
    search_key(-1000);
  endtask

  task automatic random_lookups(input int n);
    int sel, i;
    logic signed [ise_pkg::VAL_W-1:0] key;
    longint a, b;
    for (int t = 0; t < n; t++) begin
      sel = $urandom_range(0, 99);
      i = $urandom_range(0, STORE_DEPTH - 1);
      if (sel < 6) begin
        i = $urandom_range(0, STORE_DEPTH - 1);
        if ($urandom_range(0, 1) == 0) write_entry(i, shadow_store[i]);
        else write_entry(i, $urandom);
      end else begin
        if (sel < 50) begin
          key = shadow_store[i];
        end else if (sel < 65) begin
          key = shadow_store[i] + 1;
        end else if (sel < 75) begin
          key = shadow_store[i] - 1;
        end else if (sel < 85) begin
          i = $urandom_range(0, STORE_DEPTH - 2);
          a = longint'(shadow_store[i]);
          b = longint'(shadow_store[i + 1]);
          a = a + (b - a) / 2;
          key = a[ise_pkg::VAL_W-1:0];
        end else if (sel < 95) begin
          key = $urandom;
        end else begin
          key = sel[0] ? VAL_MAX : VAL_MIN;
        end
        search_key(key);
      end
    end
  endtask

  task automatic test_random_phases();
    int phase;
    int pick;
    fill_mode_t mode;
    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (phase <= int'(FILL_UNSORTED)) begin
        mode = fill_mode_t'(phase);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 25) mode = FILL_SPREAD;
        else if (pick < 50) mode = FILL_SORTED;
        else if (pick < 65) mode = FILL_CLUSTER;
        else if (pick < 73) mode = FILL_FLAT;
        else if (pick < 85) mode = FILL_SKEW;
        else mode = FILL_UNSORTED;
      end
      load_store(mode);
      random_lookups($urandom_range(10, 40));
      phase++;
    end
  endtask

  // result checker: every strobe must match the oldest pending lookup
  always @(posedge clk) begin
    ise_pkg::out_item_t want;
    if (rst_n && out_valid) begin
      if (expected_lookups.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual found=%0b position=%0d",
                 $time, out_data.found, out_data.position);
        mismatch_count++;
      end else begin
        want = expected_lookups.pop_front();
        if (out_data.found !== want.found) begin
          $display("%0t: found mismatch, expected %0b, actual %0b",
                   $time, want.found, out_data.found);
          mismatch_count++;
        end
        if (out_data.position !== want.position) begin
          $display("%0t: position mismatch, expected %0d, actual %0d",
                   $time, want.position, out_data.position);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d lookups pending", $time, expected_lookups.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_store_extremes();
    test_unsorted_store();
    test_random_phases();
    start <= 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_lookups.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
